// ===== src/assert_macros.svh =====
// Assertion macros included by the RGB to HSV converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, off while arst_n is low.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when cond holds, prop holds in the following cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/r2hsv_pkg.sv =====
// Types, constants and the reciprocal table for the RGB to HSV pipeline.
`default_nettype none

package r2hsv_pkg;

	// Channel and field widths
	localparam int CH_W    = 8;
	localparam int HUE_W   = 15;
	localparam int SAT_W   = 16;
	localparam int VAL_W   = 16;
	localparam int IN_W    = 3 * CH_W;
	localparam int OUT_W   = 48;

	// Hue scaling
	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_UNIT  = 1 << HUE_FRAC_BITS;
	localparam int HUE_SCALE = 60 * HUE_UNIT;
	localparam int HUE_HALF  = 180 * HUE_UNIT;
	localparam int HUE_FULL  = 360 * HUE_UNIT;
	localparam int HUE_OFS_G = 120 * HUE_UNIT;
	localparam int HUE_OFS_B = 240 * HUE_UNIT;

	// Hue quotient width, hue and saturation dividend widths, signed hue working width
	localparam int HQ_W = $clog2(HUE_SCALE + 1);
	localparam int NH_W = $clog2(HUE_SCALE * 255 + 128);
	localparam int NS_W = 24;
	localparam int HP_W = $clog2(HUE_FULL) + 2;

	// Reciprocal: RECIP_TAB[d] = ceil(2^RCP_SH / d); exact for dividends below 2^24
	localparam int RCP_SH = 32;
	localparam int RCP_W  = 32;

	// Bump thresholds on max (10*max > 1530, 765, 510)
	localparam int BUMP_MX_98  = 153;
	localparam int BUMP_MX_99  = 76;
	localparam int BUMP_MX_100 = 51;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef logic [255:0][RCP_W-1:0] recip_tab_t;

	// Built at elaboration by shift-subtract; entries 0 and 1 unused
	function automatic recip_tab_t make_recip_tab();
		recip_tab_t      tab;
		logic [32:0]     num;
		logic [32:0]     quo;
		logic [8:0]      rem;
		tab = '0;
		for (int d = 2; d < 256; d++) begin
			num = 33'h1_0000_0000 + 33'(d - 1);
			rem = '0;
			quo = '0;
			for (int i = 32; i >= 0; i--) begin
				rem = {rem[7:0], num[i]};
				if (rem >= 9'(d)) begin
					rem    = rem - 9'(d);
					quo[i] = 1'b1;
				end
			end
			tab[d] = quo[RCP_W-1:0];
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP_TAB = make_recip_tab();

endpackage

`default_nettype wire

// ===== src/rgb_to_hsv_signed_hue.sv =====
// Pipelined 8-bit RGB to HSV converter with signed hue.
//
//  channel  | dir | tdata bits (low to high)                  | tuser/tlast
//  ---------+-----+-------------------------------------------+------------
//  s_axis   | in  | red[7:0] green[15:8] blue[23:16]          | none
//  m_axis   | out | hue[14:0] saturation[30:15] value[46:31]  | none
//
// One pixel per clock sustained while m_axis is ready; results are registered in stages 1 to 5.
// The two reciprocal multipliers in stage 3 set the clock limit; divisions are
// exact multiplies by a constant reciprocal table indexed by the divisor.
// Each stage has its own valid bit and moves when the next stage is empty or moving,
// so bubbles are squeezed out and a stall on m_axis loses and repeats nothing.
// arst_n clears the valid bits only; no clearing pass after reset.
`default_nettype none

module rgb_to_hsv_signed_hue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [r2hsv_pkg::IN_W-1:0]    s_axis_tdata,   // red, green, blue
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [r2hsv_pkg::OUT_W-1:0]   m_axis_tdata    // hue, saturation, value, pad
);
	import r2hsv_pkg::*;

	`include "assert_macros.svh"

	// Stage valids and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !vld_s5 || m_axis_tready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_axis_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- Stage 1: max, min, sector, signed numerator ----------------
	logic [CH_W-1:0] red, green, blue;
	logic            red_max, grn_max;
	logic [CH_W-1:0] mx_c, mn_c;
	logic [CH_W:0]   diff_c;
	sector_t         sec_c;

	assign red   = s_axis_tdata[CH_W-1:0];
	assign green = s_axis_tdata[2*CH_W-1:CH_W];
	assign blue  = s_axis_tdata[3*CH_W-1:2*CH_W];

	always_comb begin
		red_max = (red >= green) && (red >= blue);
		grn_max = !red_max && (green >= blue);
		if (red_max) begin
			sec_c  = SEC_RED;
			mx_c   = red;
			diff_c = {1'b0, green} - {1'b0, blue};
		end else if (grn_max) begin
			sec_c  = SEC_GREEN;
			mx_c   = green;
			diff_c = {1'b0, blue} - {1'b0, red};
		end else begin
			sec_c  = SEC_BLUE;
			mx_c   = blue;
			diff_c = {1'b0, red} - {1'b0, green};
		end
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	logic [CH_W-1:0] max_s1, del_s1, mag_s1;
	logic            neg_s1, zero_s1;
	sector_t         sec_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			max_s1  <= mx_c;
			del_s1  <= mx_c - mn_c;
			neg_s1  <= diff_c[CH_W];
			mag_s1  <= diff_c[CH_W] ? CH_W'(-diff_c) : diff_c[CH_W-1:0];
			sec_s1  <= sec_c;
			// red is max and green equals blue: exact hue zero (gray included)
			zero_s1 <= red_max && (green == blue);
		end
	end

	// ---------------- Stage 2: dividends, reciprocals, bump ----------------
	logic [NH_W-1:0] nh_c;
	logic [NS_W-1:0] ns_c;
	logic [14:0]     del100, max98, max99;
	logic            bump_c;

	always_comb begin
		// half of the doubled rounding dividends
		nh_c = NH_W'(mag_s1) * NH_W'(HUE_SCALE) + NH_W'(del_s1 >> 1);
		ns_c = {del_s1, 16'h0000} - NS_W'(del_s1) + NS_W'(max_s1 >> 1);
		del100 = 15'(del_s1) * 15'd100;
		max98  = 15'(max_s1) * 15'd98;
		max99  = 15'(max_s1) * 15'd99;
		bump_c = (zero_s1 && (del100 >= max98) && (max_s1 > CH_W'(BUMP_MX_98)))
			|| ((del100 >= max99) && (max_s1 > CH_W'(BUMP_MX_99)))
			|| ((del_s1 >= max_s1) && (max_s1 > CH_W'(BUMP_MX_100)));
	end

	logic [NH_W-1:0]  nh_s2;
	logic [NS_W-1:0]  ns_s2;
	logic [RCP_W-1:0] rh_s2, rs_s2;
	logic             oneh_s2, ones_s2, neg_s2, bump_s2;
	sector_t          sec_s2;
	logic [CH_W-1:0]  max_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			nh_s2   <= nh_c;
			ns_s2   <= ns_c;
			rh_s2   <= RECIP_TAB[del_s1];
			rs_s2   <= RECIP_TAB[max_s1];
			oneh_s2 <= (del_s1 == CH_W'(1));
			ones_s2 <= (max_s1 == CH_W'(1));
			neg_s2  <= neg_s1;
			bump_s2 <= bump_c;
			sec_s2  <= sec_s1;
			max_s2  <= max_s1;
		end
	end

	// ---------------- Stage 3: reciprocal multiplies ----------------
	logic [NH_W+RCP_W-1:0] ph_s3;
	logic [NS_W+RCP_W-1:0] ps_s3;
	logic [HQ_W-1:0]       nhl_s3;
	logic [SAT_W-1:0]      nsl_s3;
	logic                  oneh_s3, ones_s3, neg_s3, bump_s3;
	sector_t               sec_s3;
	logic [CH_W-1:0]       max_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ph_s3   <= (NH_W+RCP_W)'(nh_s2) * (NH_W+RCP_W)'(rh_s2);
			ps_s3   <= (NS_W+RCP_W)'(ns_s2) * (NS_W+RCP_W)'(rs_s2);
			nhl_s3  <= nh_s2[HQ_W-1:0];
			nsl_s3  <= ns_s2[SAT_W-1:0];
			oneh_s3 <= oneh_s2;
			ones_s3 <= ones_s2;
			neg_s3  <= neg_s2;
			bump_s3 <= bump_s2;
			sec_s3  <= sec_s2;
			max_s3  <= max_s2;
		end
	end

	// ---------------- Stage 4: quotients, sign, sector offset ----------------
	logic [HQ_W-1:0]        qh_c;
	logic signed [HP_W-1:0] hq_sgn, offs_c;

	always_comb begin
		// divisor of one has no table entry: quotient is the dividend
		qh_c   = oneh_s3 ? nhl_s3 : ph_s3[RCP_SH +: HQ_W];
		hq_sgn = neg_s3 ? -$signed(HP_W'(qh_c)) : $signed(HP_W'(qh_c));
		case (sec_s3)
			SEC_RED:   offs_c = '0;
			SEC_GREEN: offs_c = HP_W'(HUE_OFS_G);
			SEC_BLUE:  offs_c = HP_W'(HUE_OFS_B);
			default:   offs_c = '0;
		endcase
	end

	logic signed [HP_W-1:0] hpre_s4;
	logic [HQ_W-1:0]        qh_s4;
	logic [SAT_W-1:0]       sat_s4;
	logic                   bump_s4;
	logic [CH_W-1:0]        max_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			hpre_s4 <= offs_c + hq_sgn;
			qh_s4   <= qh_c;
			sat_s4  <= ones_s3 ? nsl_s3 : ps_s3[RCP_SH +: SAT_W];
			bump_s4 <= bump_s3;
			max_s4  <= max_s3;
		end
	end

	// ---------------- Stage 5: wrap, bump, output register ----------------
	logic signed [HP_W-1:0] hwrap_c, hfin_c;

	always_comb begin
		hwrap_c = (hpre_s4 >= $signed(HP_W'(HUE_HALF))) ?
			hpre_s4 - $signed(HP_W'(HUE_FULL)) : hpre_s4;
		hfin_c  = bump_s4 ? hwrap_c + $signed(HP_W'(HUE_UNIT)) : hwrap_c;
	end

	logic [HUE_W-1:0] hue_s5;
	logic [SAT_W-1:0] sat_s5;
	logic [CH_W-1:0]  max_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			hue_s5 <= HUE_W'(hfin_c);
			sat_s5 <= sat_s4;
			max_s5 <= max_s4;
		end
	end

	// value = max * 257
	assign m_axis_tdata = {
		{(OUT_W - HUE_W - SAT_W - VAL_W){1'b0}},
		max_s5, max_s5,
		sat_s5,
		hue_s5
	};

	// ---------------- Assertions ----------------
	`ASSERT_ALWAYS(a_hue_quot_range, !vld_s4 || (qh_s4 <= HQ_W'(HUE_SCALE)), "hue quotient out of range")
	`ASSERT_ALWAYS(a_full_stall, !(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !m_axis_tready) || !s_axis_tready, "request taken into a full stalled pipe")
	`ASSERT_NEXT(a_stall_keeps, vld_s4 && vld_s5 && !m_axis_tready, vld_s4 && vld_s5, "stalled item dropped")

endmodule

`default_nettype wire
